@@ rtl/uer_pkg.sv @@
// Shared widths, register map, constants and types for the echo ranger.
package uer_pkg;

    localparam int TRIG_LEN_W  = 8;
    localparam int SCALE_W     = 12;
    localparam int CNT_W       = 16;
    localparam int SAMP_W      = 4;
    localparam int SUM_W       = 20;
    localparam int DIST_W      = 16;
    localparam int DEN_W       = SAMP_W + SCALE_W;
    localparam int DIST_MUL    = 100;
    localparam int MUL_W       = 7;
    localparam int NUM_W       = SUM_W + MUL_W;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam int SAMPLES_DEF = 5;

    localparam logic [TRIG_LEN_W-1:0] TRIG_LEN_RST = 8'd10;
    localparam logic [SCALE_W-1:0]    SCALE_RST    = 12'd588;

    // register index, taken from the word address bit
    localparam logic REG_TRIG_LEN = 1'b0;
    localparam logic REG_SCALE    = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ rtl/uer_div.sv @@
// Restoring divider, one quotient bit per cycle, saturating the quotient.
module uer_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [uer_pkg::NUM_W-1:0]     i_num,
    input  logic [uer_pkg::DEN_W-1:0]     i_den,
    output uer_pkg::t_div_stat            o_stat,
    output logic [uer_pkg::DIST_W-1:0]    o_quot
);

    localparam int QW    = uer_pkg::DIST_W;
    localparam int DW    = uer_pkg::DEN_W;
    localparam int NW    = uer_pkg::NUM_W;
    localparam int CW    = $clog2(QW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_lo;
    logic [QW-1:0] r_quot;

    logic [DW:0]   w_part;
    logic          w_ge;
    logic [DW-1:0] w_hi;

    assign w_hi   = DW'(i_num[NW-1:QW]);
    assign w_part = {r_rem, r_lo[QW-1]};
    assign w_ge   = (w_part >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                if (w_hi >= i_den) begin
                    // quotient does not fit: clamp to full scale
                    r_quot <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= w_hi;
                    r_lo   <= i_num[QW-1:0];
                    r_cnt  <= CW'(QW);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= w_ge ? DW'(w_part - {1'b0, r_den}) : w_part[DW-1:0];
                r_quot <= {r_quot[QW-2:0], w_ge};
                r_lo   <= {r_lo[QW-2:0], 1'b0};
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

@@ rtl/ultrasonic_echo_ranger.sv @@
// Ultrasonic echo ranger: trigger sequencing, echo counting, averaging.
// Every tick gives one result; a closing tick's result waits for the divider.
// The tick that closes a sequence runs the divider: it loads, runs one iteration per
// quotient bit and hands off, and skips the iterations when the result clamps.
// One tick in work at a time; a transfer needs a free result slot and no division running.
// Synchronous active-low reset clears sequencer and output slot; registers take defaults.
module ultrasonic_echo_ranger #(
    parameter int P_SAMPLES = uer_pkg::SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_start_req,
    input  logic                          i_echo_level,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_trigger_level,
    output logic                          o_busy_res,
    output logic                          o_distance_valid,
    output logic [uer_pkg::DIST_W-1:0]    o_distance_tenths_cm,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uer_pkg::PADDR_W-1:0]   paddr,
    input  logic [uer_pkg::PDATA_W-1:0]   pwdata,
    output logic [uer_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int TLW = uer_pkg::TRIG_LEN_W;
    localparam int SCW = uer_pkg::SCALE_W;
    localparam int CNW = uer_pkg::CNT_W;
    localparam int SMW = uer_pkg::SAMP_W;
    localparam int SUW = uer_pkg::SUM_W;
    localparam int NMW = uer_pkg::NUM_W;
    localparam int DNW = uer_pkg::DEN_W;
    localparam int PDW = uer_pkg::PDATA_W;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_TRIG  = 2'd1;
    localparam logic [1:0] PH_WAIT  = 2'd2;
    localparam logic [1:0] PH_COUNT = 2'd3;

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_DIV = 1'b1;

    localparam logic [uer_pkg::MUL_W-1:0] MUL_CONST = uer_pkg::MUL_W'(uer_pkg::DIST_MUL);

    logic [TLW-1:0]           r_trig_len;
    logic [SCW-1:0]           r_scale;
    logic [1:0]               r_phase,   n_phase;
    logic [TLW-1:0]           r_pulse,   n_pulse;
    logic [CNW-1:0]           r_cnt,     n_cnt;
    logic [SMW-1:0]           r_samples, n_samples;
    logic [SUW-1:0]           r_sum,     n_sum;
    logic                     r_ctl;
    logic [uer_pkg::DIST_W-1:0] r_last;
    logic                     r_out_valid;
    logic                     r_out_trig;
    logic                     r_out_busy;
    logic                     r_out_dval;

    logic                     w_accept;
    logic                     w_cfg_wr;
    logic                     n_trig;
    logic                     n_final;
    logic [SMW:0]             w_samp_inc;
    logic [SCW-1:0]           w_scale_eff;
    logic [DNW-1:0]           w_den;
    logic [NMW-1:0]           w_num;
    uer_pkg::t_div_stat       w_div_stat;
    logic [uer_pkg::DIST_W-1:0] w_quot;

    assign o_in_ready = (r_ctl == ST_RUN) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    assign prdata = (paddr[2] == uer_pkg::REG_SCALE) ? PDW'(r_scale) : PDW'(r_trig_len);

    assign w_samp_inc  = {1'b0, r_samples} + (SMW+1)'(1);
    assign w_scale_eff = (r_scale == '0) ? SCW'(1) : r_scale;
    assign w_den       = DNW'(SMW'(P_SAMPLES) * w_scale_eff);
    assign w_num       = NMW'(n_sum * MUL_CONST);

    // per-tick sequencer step
    always_comb begin
        n_phase   = r_phase;
        n_pulse   = r_pulse;
        n_cnt     = r_cnt;
        n_samples = r_samples;
        n_sum     = r_sum;
        n_trig    = 1'b0;
        n_final   = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_phase   = PH_TRIG;
                    n_pulse   = '0;
                    n_cnt     = '0;
                    n_samples = '0;
                    n_sum     = '0;
                end
            end
            PH_TRIG: begin
                if (r_pulse < r_trig_len) begin
                    n_pulse = r_pulse + TLW'(1);
                    n_trig  = 1'b1;
                end else begin
                    n_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (i_echo_level) begin
                    n_cnt   = CNW'(1);
                    n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (i_echo_level) begin
                    if (r_cnt != '1) begin
                        n_cnt = r_cnt + CNW'(1);
                    end
                end else begin
                    n_sum     = r_sum + SUW'(r_cnt);
                    n_samples = w_samp_inc[SMW-1:0];
                    n_cnt     = '0;
                    if (w_samp_inc >= (SMW+1)'(P_SAMPLES)) begin
                        n_final = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_TRIG;
                        n_pulse = '0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    uer_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && n_final),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_len  <= uer_pkg::TRIG_LEN_RST;
            r_scale     <= uer_pkg::SCALE_RST;
            r_phase     <= PH_IDLE;
            r_pulse     <= '0;
            r_cnt       <= '0;
            r_samples   <= '0;
            r_sum       <= '0;
            r_last      <= '0;
            r_ctl       <= ST_RUN;
            r_out_valid <= 1'b0;
            r_out_trig  <= 1'b0;
            r_out_busy  <= 1'b0;
            r_out_dval  <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                if (paddr[2] == uer_pkg::REG_SCALE) begin
                    r_scale <= pwdata[SCW-1:0];
                end else begin
                    r_trig_len <= pwdata[TLW-1:0];
                end
            end

            if (w_accept) begin
                r_phase   <= n_phase;
                r_pulse   <= n_pulse;
                r_cnt     <= n_cnt;
                r_samples <= n_samples;
                r_sum     <= n_sum;
                if (n_final) begin
                    // hold the result until the quotient comes back
                    r_ctl <= ST_DIV;
                end
            end

            if (w_accept && !n_final) begin
                r_out_valid <= 1'b1;
                r_out_trig  <= n_trig;
                r_out_busy  <= (n_phase != PH_IDLE);
                r_out_dval  <= 1'b0;
            end else if (r_ctl == ST_DIV && w_div_stat.done) begin
                r_ctl       <= ST_RUN;
                r_last      <= w_quot;
                r_out_valid <= 1'b1;
                r_out_trig  <= 1'b0;
                r_out_busy  <= 1'b0;
                r_out_dval  <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_trigger_level      = r_out_trig;
    assign o_busy_res           = r_out_busy;
    assign o_distance_valid     = r_out_dval;
    assign o_distance_tenths_cm = r_last;

endmodule

@@ verif/echo_ranger_checker.sv @@
// Echo ranger checker: watches both channels and the register port, predicts each tick.
module echo_ranger_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_start_req,
    input  logic                        i_echo_level,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_trigger_level,
    input  logic                        i_busy_res,
    input  logic                        i_distance_valid,
    input  logic [uer_pkg::DIST_W-1:0]  i_distance_tenths_cm,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [uer_pkg::PADDR_W-1:0] i_paddr,
    input  logic [uer_pkg::PDATA_W-1:0] i_pwdata,
    input  logic                        i_pready,
    output int                          o_mismatches,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import uer_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        RNG_IDLE,
        RNG_TRIG,
        RNG_WAIT,
        RNG_COUNT
    } t_ranger_phase;

    typedef struct packed {
        logic              trigger;
        logic              busy;
        logic              dist_valid;
        logic [DIST_W-1:0] distance;
    } t_tick_result;

    logic [TRIG_LEN_W-1:0] cfg_trig_len;
    logic [SCALE_W-1:0]    cfg_scale;

    t_ranger_phase         phase_q;
    logic [TRIG_LEN_W-1:0] pulse_ticks;
    logic [CNT_W-1:0]      echo_ticks;
    logic [SAMP_W-1:0]     samples_taken;
    logic [SUM_W-1:0]      echo_total;
    logic [DIST_W-1:0]     distance_q;

    t_tick_result tick_results_due[$];
    int           fail_total;

    function automatic logic [DIST_W-1:0] average_distance(input logic [SUM_W-1:0] total);
        logic [63:0] divisor;
        logic [63:0] quotient;
        // a zero scale divides as one
        divisor = (cfg_scale == '0) ? 64'd1 : 64'(cfg_scale);
        divisor = divisor * 64'(SAMPLES_DEF);
        quotient = (64'(total) * 64'(DIST_MUL)) / divisor;
        return (quotient > 64'hFFFF) ? '1 : quotient[DIST_W-1:0];
    endfunction

    function automatic t_tick_result ranger_tick(input logic start, input logic echo);
        t_tick_result res;
        res = '0;
        case (phase_q)
            RNG_IDLE: begin
                if (start) begin
                    phase_q       = RNG_TRIG;
                    pulse_ticks   = '0;
                    echo_ticks    = '0;
                    samples_taken = '0;
                    echo_total    = '0;
                end
            end
            RNG_TRIG: begin
                if (pulse_ticks < cfg_trig_len) begin
                    pulse_ticks = pulse_ticks + TRIG_LEN_W'(1);
                    res.trigger = 1'b1;
                end else begin
                    phase_q = RNG_WAIT;
                end
            end
            RNG_WAIT: begin
                if (echo) begin
                    echo_ticks = CNT_W'(1);
                    phase_q    = RNG_COUNT;
                end
            end
            default: begin
                if (echo) begin
                    if (echo_ticks != '1) begin
                        echo_ticks = echo_ticks + CNT_W'(1);
                    end
                end else begin
                    echo_total    = echo_total + SUM_W'(echo_ticks);
                    samples_taken = samples_taken + SAMP_W'(1);
                    echo_ticks    = '0;
                    if (samples_taken >= SAMP_W'(SAMPLES_DEF)) begin
                        distance_q     = average_distance(echo_total);
                        res.dist_valid = 1'b1;
                        phase_q        = RNG_IDLE;
                    end else begin
                        phase_q     = RNG_TRIG;
                        pulse_ticks = '0;
                    end
                end
            end
        endcase
        res.busy     = (phase_q != RNG_IDLE);
        res.distance = distance_q;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_tick_result want;
        t_tick_result got;
        if (!i_rst_n) begin
            cfg_trig_len  = TRIG_LEN_RST;
            cfg_scale     = SCALE_RST;
            phase_q       = RNG_IDLE;
            pulse_ticks   = '0;
            echo_ticks    = '0;
            samples_taken = '0;
            echo_total    = '0;
            distance_q    = '0;
            fail_total    = 0;
            tick_results_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_TRIG_LEN) begin
                    cfg_trig_len = i_pwdata[TRIG_LEN_W-1:0];
                end else begin
                    cfg_scale = i_pwdata[SCALE_W-1:0];
                end
            end
            // compare before pushing: a result never belongs to the tick taken at the same edge
            if (i_out_valid && i_out_ready) begin
                got = {i_trigger_level, i_busy_res, i_distance_valid, i_distance_tenths_cm};
                if (tick_results_due.size() == 0) begin
                    if (fail_total < REPORT_LIMIT) begin
                        $display("%0t: unexpected result trig=%0b busy=%0b valid=%0b dist=%0d",
                                 $time, got.trigger, got.busy, got.dist_valid, got.distance);
                    end
                    fail_total++;
                end else begin
                    want = tick_results_due.pop_front();
                    if (got.trigger !== want.trigger || got.busy !== want.busy ||
                        got.dist_valid !== want.dist_valid || got.distance !== want.distance) begin
                        if (fail_total < REPORT_LIMIT) begin
                            $display("%0t: mismatch exp trig=%0b busy=%0b valid=%0b dist=%0d",
                                     $time, want.trigger, want.busy, want.dist_valid,
                                     want.distance);
                            $display("%0t:          got trig=%0b busy=%0b valid=%0b dist=%0d",
                                     $time, got.trigger, got.busy, got.dist_valid,
                                     got.distance);
                        end
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                tick_results_due.push_back(ranger_tick(i_start_req, i_echo_level));
            end
        end
        o_pending    <= tick_results_due.size();
        o_mismatches <= fail_total;
    end

endmodule

@@ verif/ultrasonic_echo_ranger_tb.sv @@
// Testbench top for the echo ranger: tick stimulus, handshake pacing and verdict.
module ultrasonic_echo_ranger_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import uer_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;
    localparam int RESET_CYCLES   = 12;

    localparam int MODE_NONE = 0;
    localparam int MODE_SEND = 1;
    localparam int MODE_RECV = 2;
    localparam int MODE_BOTH = 3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                in_valid   = 1'b0;
    logic                start_req  = 1'b0;
    logic                echo_level = 1'b0;
    logic                out_ready  = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [PADDR_W-1:0]  paddr      = '0;
    logic [PDATA_W-1:0]  pwdata     = '0;

    logic                in_ready;
    logic                out_valid;
    logic                trigger_level;
    logic                busy_res;
    logic                distance_valid;
    logic [DIST_W-1:0]   distance_tenths_cm;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int mismatch_total;
    int results_due;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int ticks_sent     = 0;
    int quiet_cycles   = 0;
    logic [TRIG_LEN_W-1:0] trig_len_now = TRIG_LEN_RST;

    ultrasonic_echo_ranger u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_start_req          (start_req),
        .i_echo_level         (echo_level),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_trigger_level      (trigger_level),
        .o_busy_res           (busy_res),
        .o_distance_valid     (distance_valid),
        .o_distance_tenths_cm (distance_tenths_cm),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    echo_ranger_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_start_req          (start_req),
        .i_echo_level         (echo_level),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_trigger_level      (trigger_level),
        .i_busy_res           (busy_res),
        .i_distance_valid     (distance_valid),
        .i_distance_tenths_cm (distance_tenths_cm),
        .i_psel               (psel),
        .i_penable            (penable),
        .i_pwrite             (pwrite),
        .i_paddr              (paddr),
        .i_pwdata             (pwdata),
        .i_pready             (pready),
        .o_mismatches         (mismatch_total),
        .o_pending            (results_due)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ultrasonic_echo_ranger regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put_tick(input logic start, input logic echo);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        start_req  <= start;
        echo_level <= echo;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        ticks_sent++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic sel, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [TRIG_LEN_W-1:0] trig, input logic [SCALE_W-1:0] scale,
                             input int mode);
        hold_until_drained();
        apb_write(REG_TRIG_LEN, PDATA_W'(trig));
        apb_write(REG_SCALE, PDATA_W'(scale));
        trig_len_now   = trig;
        send_gap_pct   <= (mode == MODE_SEND) ? 49 : (mode == MODE_BOTH) ? 30 : 0;
        recv_stall_pct <= (mode == MODE_RECV) ? 49 : (mode == MODE_BOTH) ? 30 : 0;
    endtask

    // low ticks cover the pulse and reach the wait phase, then the echo, then one low to close
    task automatic send_measurement(input int high_ticks);
        int lead;
        lead = int'(trig_len_now) + 1 + $urandom_range(3);
        repeat (lead) put_tick($urandom_range(3) == 0, 1'b0);
        repeat (high_ticks) put_tick($urandom_range(3) == 0, 1'b1);
        put_tick($urandom_range(3) == 0, 1'b0);
    endtask

    task automatic send_sequence(input int phase_end);
        int m;
        put_tick(1'b1, 1'($urandom_range(1)));
        for (m = 0; m < SAMPLES_DEF && ticks_sent < phase_end; m++) begin
            send_measurement(($urandom_range(9) == 0) ? $urandom_range(400, 100)
                                                      : $urandom_range(20, 1));
        end
    endtask

    task automatic run_phase(input logic [TRIG_LEN_W-1:0] trig, input logic [SCALE_W-1:0] scale,
                             input int mode, input int budget);
        int  phase_end;
        bit  paused;
        configure(trig, scale, mode);
        phase_end = ticks_sent + budget;
        paused    = 1'b0;
        while (ticks_sent < phase_end) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(30, 5)) put_tick(1'($urandom_range(1)),
                                                        1'($urandom_range(1)));
            end else begin
                send_sequence(phase_end);
            end
            // stop sending once per phase until the block has caught up
            if (!paused) begin
                hold_until_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero pulse length and zero scale, echo and start while idle or busy
        configure('0, '0, MODE_NONE);
        put_tick(1'b0, 1'b1);
        put_tick(1'b0, 1'b0);
        put_tick(1'b1, 1'b1);
        repeat (SAMPLES_DEF) begin
            put_tick(1'b1, 1'b0);
            put_tick(1'b1, 1'b1);
            put_tick(1'b0, 1'b0);
        end

        run_phase(8'd10,  12'd588,  MODE_NONE, 250);
        run_phase(8'd1,   12'd4095, MODE_SEND, 250);
        run_phase(8'd3,   12'd1,    MODE_RECV, 250);
        run_phase(8'd255, 12'd588,  MODE_BOTH, 300);
        run_phase(8'd0,   12'd37,   MODE_NONE, 250);
        run_phase(8'd7,   12'd2048, MODE_SEND, 200);
        run_phase(8'd2,   12'd1000, MODE_BOTH, 200);

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_total == 0 && results_due == 0) begin
            $display("ultrasonic_echo_ranger regression: pass");
        end else begin
            $display("ultrasonic_echo_ranger regression: fail");
        end
        $finish;
    end

endmodule
